/* hw/rtl/rgb_to_hsv_hsl_converter_top_assert.svh */
// ----------------------------------------------------------------------------
// RGB to HSV/HSL converter assertion macros
// Property macros for the converter checks; they expand to nothing in
// synthesis builds.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_HSL_CONVERTER_TOP_ASSERT_SVH
`define RGB_TO_HSV_HSL_CONVERTER_TOP_ASSERT_SVH

`ifndef SYNTH

// Check that an expression holds at every clock edge out of reset
`define RHC_ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("rgb_to_hsv_hsl_converter: invariant check failed");

// Check that a condition implies a consequence in the same cycle
`define RHC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgb_to_hsv_hsl_converter: implication check failed");

`else

`define RHC_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define RHC_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`endif

`endif

/* hw/rtl/rgbhsv_pkg.sv */
// ----------------------------------------------------------------------------
// RGB to HSV/HSL converter package
// Word types, operand types and fixed constants shared by the converter.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

  // Operand width of the fraction dividers: holds 6 * (max - min) <= 1530
  localparam int DW = 11;

  // Quotient bits produced per divider stage
  localparam int DIV_SPS = 4;

  localparam logic [DW-1:0] LVL_DEN_HSL = 11'd510;
  localparam logic [8:0]    HALF_SUM    = 9'd255;

  localparam logic MODE_HSV = 1'b0;
  localparam logic MODE_HSL = 1'b1;

  typedef enum logic [1:0] {
    SEL_RED,
    SEL_GREEN,
    SEL_BLUE
  } max_sel_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic [15:0] hue;
    logic [15:0] saturation;
    logic [15:0] level;
  } hsx_t;

  typedef struct packed {
    logic [DW-1:0] num;
    logic [DW-1:0] den;
  } div_op_t;

  typedef struct packed {
    div_op_t     hue;
    div_op_t     sat;
    logic [15:0] lvl;
  } ops_t;

endpackage

/* hw/rtl/rgbhsv_prep.sv */
// ----------------------------------------------------------------------------
// Operand preparation
// Two register stages: max/min/delta/sum of the pixel, then the numerator
// and denominator of hue and saturation for the dividers, and the level.
// ----------------------------------------------------------------------------
module rgbhsv_prep #(
  parameter int FracBits = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  rgbhsv_pkg::pix_t   pix_i,
  input  logic               mode_i,
  output logic               valid_o,
  output rgbhsv_pkg::ops_t   ops_o
);
  import rgbhsv_pkg::*;

  // Level by 255: a byte over 255 repeats below the binary point
  localparam int HsvN = (FracBits + 7) / 8;
  localparam int HsvE = 8 * HsvN - FracBits;
  localparam int HslN = (FracBits + 6) / 8;
  localparam int HslE = 8 * HslN - FracBits + 1;
  localparam int LW   = (8 * HsvN > 16) ? 8 * HsvN : 16;

  // Stage 1 signals
  logic [7:0] mx_d, mn_d;
  max_sel_e   sel_d;

  logic       vld1_q;
  pix_t       pix1_q;
  logic [7:0] mx1_q;
  logic [7:0] d1_q;
  logic [8:0] sum1_q;
  max_sel_e   sel1_q;
  logic       mode1_q;

  // Stage 2 signals
  logic [DW-1:0] d11, d6, base, xa, xb;
  logic [7:0]    lr;
  logic [LW-1:0] lvl_w;
  ops_t          ops_d;
  logic          vld2_q;
  ops_t          ops2_q;

  // Find the largest channel (red, green, blue order on ties) and the smallest
  always_comb begin
    mx_d  = pix_i.red;
    sel_d = SEL_RED;
    if (pix_i.green > mx_d) begin
      mx_d  = pix_i.green;
      sel_d = SEL_GREEN;
    end
    if (pix_i.blue > mx_d) begin
      mx_d  = pix_i.blue;
      sel_d = SEL_BLUE;
    end
    mn_d = pix_i.red;
    if (pix_i.green < mn_d) begin
      mn_d = pix_i.green;
    end
    if (pix_i.blue < mn_d) begin
      mn_d = pix_i.blue;
    end
  end

  // Stage 1 valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else begin
      vld1_q <= valid_i;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk_i) begin
    pix1_q  <= pix_i;
    mx1_q   <= mx_d;
    d1_q    <= mx_d - mn_d;
    sum1_q  <= {1'b0, mx_d} + {1'b0, mn_d};
    sel1_q  <= sel_d;
    mode1_q <= mode_i;
  end

  // Build divider operands and the level
  always_comb begin
    d11 = DW'(d1_q);
    d6  = (d11 << 2) + (d11 << 1);

    // Hue numerator: k*d + (x - y); wraps in DW bits to a nonnegative value
    base = '0;
    xa   = '0;
    xb   = '0;
    case (sel1_q)
      SEL_RED: begin
        base = (pix1_q.green < pix1_q.blue) ? d6 : '0;
        xa   = DW'(pix1_q.green);
        xb   = DW'(pix1_q.blue);
      end
      SEL_GREEN: begin
        base = d11 << 1;
        xa   = DW'(pix1_q.blue);
        xb   = DW'(pix1_q.red);
      end
      SEL_BLUE: begin
        base = d11 << 2;
        xa   = DW'(pix1_q.red);
        xb   = DW'(pix1_q.green);
      end
      default: begin
        base = '0;
        xa   = '0;
        xb   = '0;
      end
    endcase

    ops_d.hue.num = base + xa - xb;
    ops_d.hue.den = d6;

    if (mode1_q == MODE_HSV) begin
      ops_d.sat.num = d11;
      ops_d.sat.den = DW'(mx1_q);
      // max/255: the max byte repeated, 255 lands on all ones
      lr    = '0;
      lvl_w = LW'({HsvN{mx1_q}} >> HsvE);
    end else begin
      ops_d.sat.num = d11;
      ops_d.sat.den = (sum1_q > HALF_SUM) ? (LVL_DEN_HSL - DW'(sum1_q)) : DW'(sum1_q);
      // sum/510: one half once the sum reaches 255, plus the remainder byte repeated
      if (sum1_q >= HALF_SUM) begin
        lr    = 8'(sum1_q - HALF_SUM);
        lvl_w = LW'({HslN{lr}} >> HslE) + (LW'(1) << (FracBits - 1));
      end else begin
        lr    = sum1_q[7:0];
        lvl_w = LW'({HslN{lr}} >> HslE);
      end
    end

    // Clamp the level to 16 bits
    ops_d.lvl = (lvl_w > LW'(65535)) ? 16'hFFFF : lvl_w[15:0];

    // Grey pixel: force hue and saturation to zero
    if (d1_q == 8'd0) begin
      ops_d.hue.num = '0;
      ops_d.hue.den = DW'(1);
      ops_d.sat.num = '0;
      ops_d.sat.den = DW'(1);
    end
  end

  // Stage 2 valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
    end else begin
      vld2_q <= vld1_q;
    end
  end

  // Stage 2 payload
  always_ff @(posedge clk_i) begin
    ops2_q <= ops_d;
  end

  assign valid_o = vld2_q;
  assign ops_o   = ops2_q;

endmodule

/* hw/rtl/rgbhsv_div.sv */
// ----------------------------------------------------------------------------
// Pipelined fraction divider
// Restoring division of num/den (num <= den) into FracBits quotient bits,
// four bits per register stage, saturated to full scale and to 16 bits.
// ----------------------------------------------------------------------------
module rgbhsv_div #(
  parameter int FracBits = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  rgbhsv_pkg::div_op_t op_i,
  output logic                valid_o,
  output logic [15:0]         quot_o
);
  import rgbhsv_pkg::*;

  localparam int SPS = DIV_SPS;
  localparam int NS  = (FracBits + SPS - 1) / SPS;
  localparam int QW  = (FracBits > 16) ? FracBits : 16;
  localparam logic [QW-1:0] SAT_MAX = QW'((FracBits > 16) ? 65535 : ((1 << FracBits) - 1));

  // Stage registers, index s holds the output of stage s
  logic                vld_q  [NS];
  logic [DW-1:0]       rem_q  [NS];
  logic [DW-1:0]       den_q  [NS];
  logic [FracBits-1:0] q_q    [NS];
  logic                full_q [NS];

  logic [QW-1:0] qx, res;

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic                vld_src, full_src;
    logic [DW-1:0]       rem_src, den_src;
    logic [FracBits-1:0] q_src;
    logic [DW-1:0]       rem_d;
    logic [FracBits-1:0] q_d;
    logic [DW:0]         two_rem;

    // Select stage input: ports for the first stage, else previous stage
    if (s == 0) begin : g_first
      assign vld_src  = valid_i;
      assign rem_src  = op_i.num;
      assign den_src  = op_i.den;
      assign q_src    = '0;
      assign full_src = (op_i.num == op_i.den);
    end else begin : g_next
      assign vld_src  = vld_q[s-1];
      assign rem_src  = rem_q[s-1];
      assign den_src  = den_q[s-1];
      assign q_src    = q_q[s-1];
      assign full_src = full_q[s-1];
    end

    // Produce up to SPS quotient bits
    always_comb begin
      rem_d   = rem_src;
      q_d     = q_src;
      two_rem = '0;
      for (int k = 0; k < SPS; k++) begin
        if (s * SPS + k < FracBits) begin
          two_rem = {rem_d, 1'b0};
          if (two_rem >= {1'b0, den_src}) begin
            rem_d = DW'(two_rem - {1'b0, den_src});
            q_d   = {q_d[FracBits-2:0], 1'b1};
          end else begin
            rem_d = two_rem[DW-1:0];
            q_d   = {q_d[FracBits-2:0], 1'b0};
          end
        end
      end
    end

    // Advance valid
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_src;
      end
    end

    // Advance payload
    always_ff @(posedge clk_i) begin
      rem_q[s]  <= rem_d;
      den_q[s]  <= den_src;
      q_q[s]    <= q_d;
      full_q[s] <= full_src;
    end
  end

  // Saturate an exact 1.0 and anything above 16 bits
  always_comb begin
    qx = QW'(q_q[NS-1]);
    if (full_q[NS-1] || (qx > SAT_MAX)) begin
      res = SAT_MAX;
    end else begin
      res = qx;
    end
  end

  assign valid_o = vld_q[NS-1];
  assign quot_o  = res[15:0];

endmodule

/* hw/rtl/rgb_to_hsv_hsl_converter_top.sv */
// ----------------------------------------------------------------------------
// RGB to HSV/HSL converter
// Converts one 8-bit RGB pixel per clock to hue, saturation and value or
// lightness as 16-bit unsigned fractions.
// ----------------------------------------------------------------------------
//  channel  | handshake                   | word
//  ---------+-----------------------------+--------------------------------
//  pixel in | start, busy (always low)    | pix_i  : red, green, blue
//  result   | done_o strobe, one cycle    | res_o  : hue, saturation, level
//  config   | cfg_valid_i, cfg_ready_o    | cfg_data_i : output mode
//
// One pixel is taken every cycle; each result passes operand preparation,
// then the divider pipeline producing four quotient bits per stage, then
// the output register. Reset clears all valid bits and selects HSV.
// The receiver cannot stall, so the pipeline never holds; busy stays low.
// ----------------------------------------------------------------------------
`include "rgb_to_hsv_hsl_converter_top_assert.svh"

module rgb_to_hsv_hsl_converter_top #(
  parameter int FRACTION_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  rgbhsv_pkg::pix_t  pix_i,
  output logic              done_o,
  output rgbhsv_pkg::hsx_t  res_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_data_i
);
  import rgbhsv_pkg::*;

  // Level waits as many stages as the dividers take
  localparam int LvlStages = (FRACTION_BITS + DIV_SPS - 1) / DIV_SPS;

  logic        mode_q, mode_d;
  logic        accept;
  logic        prep_vld;
  ops_t        prep_ops;
  logic        hue_vld, sat_vld;
  logic [15:0] hue_quot, sat_quot;
  logic [15:0] lvl_q [LvlStages];
  logic        done_q;
  hsx_t        res_q, res_d;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start & ~busy;

  // Mode register
  assign mode_d = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_HSV;
    end else begin
      mode_q <= mode_d;
    end
  end

  // Operand preparation
  rgbhsv_prep #(.FracBits(FRACTION_BITS)) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .pix_i   (pix_i),
    .mode_i  (mode_q),
    .valid_o (prep_vld),
    .ops_o   (prep_ops)
  );

  // Two divider lanes
  rgbhsv_div #(.FracBits(FRACTION_BITS)) u_div_hue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_vld),
    .op_i    (prep_ops.hue),
    .valid_o (hue_vld),
    .quot_o  (hue_quot)
  );

  rgbhsv_div #(.FracBits(FRACTION_BITS)) u_div_sat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_vld),
    .op_i    (prep_ops.sat),
    .valid_o (sat_vld),
    .quot_o  (sat_quot)
  );

  // Delay the level alongside the dividers
  always_ff @(posedge clk_i) begin
    lvl_q[0] <= prep_ops.lvl;
    for (int i = 1; i < LvlStages; i++) begin
      lvl_q[i] <= lvl_q[i-1];
    end
  end

  // Assemble the result word
  always_comb begin
    res_d.hue        = hue_quot;
    res_d.saturation = sat_quot;
    res_d.level      = lvl_q[LvlStages-1];
  end

  // Output strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= hue_vld;
    end
  end

  // Output word
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // Divider lanes advance in lock step
  `RHC_ASSERT_ALWAYS(a_lanes_aligned, clk_i, rst_ni, hue_vld == sat_vld)
  // Nonzero hue only for a colored pixel, which has nonzero saturation
  `RHC_ASSERT_IMPL(a_hue_needs_sat, clk_i, rst_ni, done_o && res_o.hue != 16'd0, res_o.saturation != 16'd0)
  // Zero saturation means a grey pixel, which has zero hue
  `RHC_ASSERT_IMPL(a_grey_hue, clk_i, rst_ni, done_o && res_o.saturation == 16'd0, res_o.hue == 16'd0)

endmodule

/* verif/rgb_to_hsv_hsl_converter_top_test.sv */
// ----------------------------------------------------------------------------
// RGB to HSV/HSL converter testbench
// Sends corner-case pixels in both modes, then random pixel bursts with
// random gaps in several mode phases. A scoreboard predicts each result and
// compares it field by field with the result word from the block.
// ----------------------------------------------------------------------------
module rgb_to_hsv_hsl_converter_top_test;
  import rgbhsv_pkg::*;

  localparam int          FRAC_BITS    = 16;
  localparam longint      FULL_SCALE   = (64'd1 << FRAC_BITS) - 1;
  localparam int          PHASE_WORDS  = 234;
  localparam int          PHASE_COUNT  = 6;
  localparam int          IDLE_LIMIT   = 2000;
  localparam int          SETTLE_TICKS = 20;
  localparam int          REPORT_LIMIT = 10;

  // Predicts converter results and holds them until they come back
  class hsx_scoreboard;
    logic        mode;
    hsx_t        pending_hsx[$];
    int unsigned fail_cnt;

    function new();
      mode     = MODE_HSV;
      fail_cnt = 0;
    endfunction

    // floor(num * 2^FRAC_BITS / den), clamped to full scale and 16 bits
    function logic [15:0] scaled_ratio(int num, int den);
      longint q;
      if (den == 0) return '0;
      q = (longint'(num) << FRAC_BITS) / longint'(den);
      if (q > FULL_SCALE) q = FULL_SCALE;
      if (q > 65535) q = 65535;
      return q[15:0];
    endfunction

    function hsx_t convert_pixel(pix_t p);
      int        r, g, b, max_c, min_c, diff, sum, num;
      max_sel_e  sel;
      hsx_t      res;
      r = int'(p.red);
      g = int'(p.green);
      b = int'(p.blue);
      // pick the largest channel, ties going to red then green
      sel   = SEL_RED;
      max_c = r;
      if (g > max_c) begin
        max_c = g;
        sel   = SEL_GREEN;
      end
      if (b > max_c) begin
        max_c = b;
        sel   = SEL_BLUE;
      end
      min_c = r;
      if (g < min_c) min_c = g;
      if (b < min_c) min_c = b;
      diff = max_c - min_c;
      sum  = max_c + min_c;
      res  = '0;

      // hue in sixths of a turn; grey keeps hue at zero
      if (diff != 0) begin
        case (sel)
          SEL_RED:   num = (g < b) ? 6 * diff - (b - g) : g - b;
          SEL_GREEN: num = 2 * diff + b - r;
          default:   num = 4 * diff + r - g;
        endcase
        res.hue = scaled_ratio(num, 6 * diff);
      end

      if (mode == MODE_HSV) begin
        if (diff != 0) res.saturation = scaled_ratio(diff, max_c);
        res.level = scaled_ratio(max_c, 255);
      end else begin
        if (diff != 0) begin
          if (sum > 255) res.saturation = scaled_ratio(diff, 510 - sum);
          else           res.saturation = scaled_ratio(diff, sum);
        end
        res.level = scaled_ratio(sum, 510);
      end
      return res;
    endfunction

    function void note_pixel(pix_t p);
      pending_hsx.push_back(convert_pixel(p));
    endfunction

    function void check_result(hsx_t got);
      hsx_t want;
      if (pending_hsx.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= REPORT_LIMIT)
          $display("unexpected result word: hue %0d sat %0d level %0d",
                   got.hue, got.saturation, got.level);
        return;
      end
      want = pending_hsx.pop_front();
      if (got !== want) begin
        fail_cnt++;
        if (fail_cnt <= REPORT_LIMIT)
          $display("result mismatch: expected hue %0d sat %0d level %0d,",
                   want.hue, want.saturation, want.level,
                   " got hue %0d sat %0d level %0d",
                   got.hue, got.saturation, got.level);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  pix_t pix_i;
  logic done_o;
  hsx_t res_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic cfg_data_i;

  hsx_scoreboard sb;
  int unsigned   idle_cnt = 0;

  // Corner pixels: black, white, mid grey, primaries, ties between maxima,
  // red maximum with green below blue, blue and green maxima, lightness at
  // and just above one half
  logic [23:0] corner_px [13] = '{
    24'h000000, 24'hFFFFFF, 24'h808080, 24'hFF0000, 24'h00FF00,
    24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF0001, 24'h0A14C8,
    24'h64C832, 24'hFF0100, 24'hFF0101
  };

  rgb_to_hsv_hsl_converter_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .pix_i       (pix_i),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // Clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Note accepted words, check results, track the mode and watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.mode = cfg_data_i;
      if (start && !busy) sb.note_pixel(pix_i);
      if (done_o) sb.check_result(res_o);
      if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) idle_cnt = 0;
      else idle_cnt++;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Drive one pixel word and hold it until accepted; enter and leave at a falling edge
  task automatic send_pixel(input pix_t p);
    pix_i <= p;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // Hold off the sender until every pending result has come back
  task automatic drain_results();
    start <= 1'b0;
    while (sb.pending_hsx.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_corners();
    foreach (corner_px[i]) send_pixel(pix_t'(corner_px[i]));
    idle_cycles(1);
  endtask

  function automatic pix_t random_pixel();
    pix_t p;
    logic [7:0] v;
    p = pix_t'(24'($urandom));
    case ($urandom_range(9))
      0: begin
        // grey
        v = 8'($urandom_range(255));
        p = '{v, v, v};
      end
      1: p.green = p.red;
      2: p.blue = p.green;
      3: p.blue = p.red;
      4: begin
        // red and green at the extremes, blue at full scale or random
        p.red   = $urandom_range(1) ? 8'hFF : 8'h00;
        p.green = $urandom_range(1) ? 8'hFF : 8'h00;
        p.blue  = $urandom_range(1) ? 8'hFF : 8'($urandom_range(255));
      end
      5: begin
        // dark pixels, small divisors
        p.red   = 8'($urandom_range(3));
        p.green = 8'($urandom_range(3));
        p.blue  = 8'($urandom_range(3));
      end
      default: ;
    endcase
    return p;
  endfunction

  // Random bursts with random gaps, including long gap-free stretches
  task automatic send_random(input int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = ($urandom_range(4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
      for (int i = 0; i < burst && sent < count; i++) begin
        send_pixel(random_pixel());
        sent++;
      end
      if ($urandom_range(2) != 0) idle_cycles($urandom_range(1, 8));
    end
  endtask

  initial begin
    sb          = new();
    rst_ni      = 1'b0;
    start       = 1'b0;
    pix_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // corners in the reset mode, then in lightness mode
    send_corners();
    drain_results();
    write_mode(MODE_HSL);
    send_corners();
    drain_results();

    // random phases, alternating the mode between them
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      write_mode((ph % 2 == 0) ? MODE_HSV : MODE_HSL);
      send_random(PHASE_WORDS);
      drain_results();
    end

    idle_cycles(SETTLE_TICKS);
    if (sb.fail_cnt == 0 && sb.pending_hsx.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/rgbhsv_pkg.sv
hw/rtl/rgbhsv_prep.sv
hw/rtl/rgbhsv_div.sv
hw/rtl/rgb_to_hsv_hsl_converter_top.sv
verif/rgb_to_hsv_hsl_converter_top_test.sv
